>>> rtl/core/cors_pkg.sv
// shared types and constants for the comment owner range search block
`timescale 1ns / 1ps

package cors_pkg;

    localparam int NODE_CAPACITY_DEF = 1024;
    localparam int NODE_IDX_W        = 10;
    localparam int NODE_COUNT_W      = 11;
    localparam int POS_W             = 32;
    localparam int CFG_DATA_W        = 11;
    localparam int CFG_IDX_W         = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NODE  = 1'd1;

    // input operation codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // how the owner was found
    localparam logic [1:0] HOW_ENCLOSING = 2'd0;
    localparam logic [1:0] HOW_PRECEDING = 2'd1;
    localparam logic [1:0] HOW_FOLLOWING = 2'd2;
    localparam logic [1:0] HOW_ROOT      = 2'd3;

    typedef struct packed {
        logic                  func;
        logic [NODE_IDX_W-1:0] node_index;
        logic [POS_W-1:0]      range_first;
        logic [POS_W-1:0]      range_last;
        logic [POS_W-1:0]      comment_offset;
        logic [POS_W-1:0]      comment_length;
        logic                  comment_trailing;
    } t_in_item;

    typedef struct packed {
        logic [NODE_IDX_W-1:0] owner_idx;
        logic [1:0]            owner_how;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN
    } t_state;

endpackage

>>> rtl/core/cors_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module cors_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/cors_scan.sv
// scan datapath: compares each table entry against the query and keeps the best owners
`timescale 1ns / 1ps

module cors_scan
    import cors_pkg::*;
#(
    parameter int ADDR_W = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic                  i_issue,
    input  logic [ADDR_W-1:0]     i_issue_addr,
    input  logic [2*POS_W-1:0]    i_rdata,
    input  logic [POS_W-1:0]      i_offset,
    input  logic [POS_W-1:0]      i_cend,
    input  logic                  i_trailing,
    input  logic [NODE_IDX_W-1:0] i_root_node,
    output logic                  o_busy,
    output t_out_item             o_result
);

    // read return tracking
    logic              r_rd_vld;
    logic [ADDR_W-1:0] r_rd_idx;

    // compare stage
    logic              r_a_vld;
    logic [ADDR_W-1:0] r_a_idx;
    logic [POS_W-1:0]  r_a_start;
    logic [POS_W-1:0]  r_a_end;
    logic [POS_W-1:0]  r_a_span;
    logic              r_a_in;
    logic              r_a_bef;
    logic              r_a_aft;

    // best candidates
    logic              r_in_found;
    logic [ADDR_W-1:0] r_in_idx;
    logic [POS_W-1:0]  r_in_span;
    logic              r_bf_found;
    logic [ADDR_W-1:0] r_bf_idx;
    logic [POS_W-1:0]  r_bf_end;
    logic [POS_W-1:0]  r_bf_span;
    logic              r_af_found;
    logic [ADDR_W-1:0] r_af_idx;
    logic [POS_W-1:0]  r_af_start;
    logic [POS_W-1:0]  r_af_span;

    logic [POS_W-1:0] rd_start;
    logic [POS_W-1:0] rd_end;
    logic             rd_blank;
    logic             n_in_take;
    logic             n_bf_take;
    logic             n_af_take;

    assign rd_start = i_rdata[2*POS_W-1:POS_W];
    assign rd_end   = i_rdata[POS_W-1:0];
    assign rd_blank = (rd_start == '0) && (rd_end == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_a_vld  <= 1'b0;
        end else begin
            r_rd_vld <= i_issue;
            r_a_vld  <= r_rd_vld;
        end
        r_rd_idx  <= i_issue_addr;
        r_a_idx   <= r_rd_idx;
        r_a_start <= rd_start;
        r_a_end   <= rd_end;
        r_a_span  <= rd_end - rd_start;
        r_a_in    <= !rd_blank && (i_offset >= rd_start) && (i_offset < rd_end);
        r_a_bef   <= !rd_blank && (rd_end <= i_offset);
        r_a_aft   <= !rd_blank && (rd_start >= i_cend);
    end

    always_comb begin
        n_in_take = r_a_vld && r_a_in && (!r_in_found || (r_a_span < r_in_span));
        n_bf_take = r_a_vld && r_a_bef &&
                    (!r_bf_found || (r_a_end > r_bf_end) ||
                     ((r_a_end == r_bf_end) && (r_a_span < r_bf_span)));
        n_af_take = r_a_vld && r_a_aft &&
                    (!r_af_found || (r_a_start < r_af_start) ||
                     ((r_a_start == r_af_start) && (r_a_span < r_af_span)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_in_found <= 1'b0;
            r_bf_found <= 1'b0;
            r_af_found <= 1'b0;
        end else begin
            if (n_in_take) begin
                r_in_found <= 1'b1;
            end
            if (n_bf_take) begin
                r_bf_found <= 1'b1;
            end
            if (n_af_take) begin
                r_af_found <= 1'b1;
            end
        end
        if (n_in_take) begin
            r_in_idx  <= r_a_idx;
            r_in_span <= r_a_span;
        end
        if (n_bf_take) begin
            r_bf_idx  <= r_a_idx;
            r_bf_end  <= r_a_end;
            r_bf_span <= r_a_span;
        end
        if (n_af_take) begin
            r_af_idx   <= r_a_idx;
            r_af_start <= r_a_start;
            r_af_span  <= r_a_span;
        end
    end

    assign o_busy = r_rd_vld || r_a_vld;

    always_comb begin
        priority if (r_in_found) begin
            o_result.owner_idx = NODE_IDX_W'(r_in_idx);
            o_result.owner_how = HOW_ENCLOSING;
        end else if (i_trailing && r_bf_found) begin
            o_result.owner_idx = NODE_IDX_W'(r_bf_idx);
            o_result.owner_how = HOW_PRECEDING;
        end else if (!i_trailing && r_af_found) begin
            o_result.owner_idx = NODE_IDX_W'(r_af_idx);
            o_result.owner_how = HOW_FOLLOWING;
        end else begin
            o_result.owner_idx = i_root_node;
            o_result.owner_how = HOW_ROOT;
        end
    end

endmodule

>>> rtl/core/comment_owner_range_search.sv
// top level: node range table, query sequencer and output register
`timescale 1ns / 1ps

// Finds the syntax node that owns a comment.
// Input channel (i_valid / o_stall, payload i_data): a load beat writes one
// node range into the table and gives no result. A query beat scans table
// entries 0 .. min(node_count, NODE_CAPACITY)-1, one entry read per cycle
// from the range ram, and returns one result. When that search length is
// zero the scan is skipped. After a query is accepted, o_stall stays high
// until the result has entered the output register.
// Output channel (o_valid / i_stall, payload o_data): the result sits in an
// output register; while the receiver stalls, new loads and a new query are
// still taken, and a finished query waits in its last step until the output
// register is free.
// The user must write configuration (i_cfg_we, i_cfg_idx, i_cfg_data) only
// while idle; the block does not enforce it. Reset (i_rst_n low,
// synchronous) clears node_count, root_node and all control state; the
// range table holds garbage until loaded, and no clearing pass is run.

module comment_owner_range_search
    import cors_pkg::*;
#(
    parameter int NODE_CAPACITY = NODE_CAPACITY_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_item              i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_item             o_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ADDR_W = (NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1;
    localparam int CAP_W  = $clog2(NODE_CAPACITY + 1);
    localparam int LIM_W  = (CAP_W > NODE_COUNT_W) ? CAP_W : NODE_COUNT_W;
    localparam logic [LIM_W-1:0] CAP_LIM = LIM_W'(NODE_CAPACITY);

    t_state                r_state;
    t_state                n_state;
    logic [NODE_COUNT_W-1:0] r_node_count;
    logic [NODE_IDX_W-1:0] r_root_node;
    logic [LIM_W-1:0]      r_lim;
    logic [ADDR_W-1:0]     r_addr;
    logic [POS_W-1:0]      r_offset;
    logic [POS_W-1:0]      r_cend;
    logic                  r_trailing;
    logic                  r_out_vld;
    t_out_item             r_out;

    logic             in_take;
    logic             load_take;
    logic             query_take;
    logic             out_take;
    logic             scan_last;
    logic             issue;
    logic             fin_load;
    logic             scan_busy;
    logic [LIM_W-1:0] lim;
    logic             load_in_range;
    logic [2*POS_W-1:0] rdata;
    t_out_item        scan_result;

    assign o_stall    = (r_state != ST_IDLE);
    assign in_take    = i_valid && !o_stall;
    assign load_take  = in_take && (i_data.func == FUNC_LOAD);
    assign query_take = in_take && (i_data.func == FUNC_QUERY);
    assign out_take   = r_out_vld && !i_stall;

    assign lim = (LIM_W'(r_node_count) > CAP_LIM) ? CAP_LIM : LIM_W'(r_node_count);
    assign load_in_range = LIM_W'(i_data.node_index) < CAP_LIM;
    assign scan_last = ((LIM_W'(r_addr) + LIM_W'(1)) == r_lim);
    assign issue     = (r_state == ST_SCAN);

    always_comb begin
        n_state  = r_state;
        fin_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (query_take) begin
                    n_state = (lim == '0) ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!scan_busy) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // wait for the output register to free up
                if (!r_out_vld || out_take) begin
                    fin_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_node_count <= '0;
            r_root_node  <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                    CFG_ROOT_NODE:  r_root_node  <= i_cfg_data[NODE_IDX_W-1:0];
                    default: ;
                endcase
            end
            if (fin_load) begin
                r_out_vld <= 1'b1;
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
        end
        if (query_take) begin
            r_lim      <= lim;
            r_offset   <= i_data.comment_offset;
            r_cend     <= i_data.comment_offset + i_data.comment_length;
            r_trailing <= i_data.comment_trailing;
        end
        if (query_take) begin
            r_addr <= '0;
        end else if (issue) begin
            r_addr <= r_addr + ADDR_W'(1);
        end
        if (fin_load) begin
            r_out <= scan_result;
        end
    end

    cors_ram #(
        .WIDTH  (2 * POS_W),
        .DEPTH  (NODE_CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_ranges (
        .i_clk   (i_clk),
        .i_we    (load_take && load_in_range),
        .i_waddr (ADDR_W'(i_data.node_index)),
        .i_wdata ({i_data.range_first, i_data.range_last}),
        .i_re    (issue),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    cors_scan #(
        .ADDR_W (ADDR_W)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (query_take),
        .i_issue      (issue),
        .i_issue_addr (r_addr),
        .i_rdata      (rdata),
        .i_offset     (r_offset),
        .i_cend       (r_cend),
        .i_trailing   (r_trailing),
        .i_root_node  (r_root_node),
        .o_busy       (scan_busy),
        .o_result     (scan_result)
    );

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

>>> test/cors_owner_checker.sv
// checker for the comment owner search: tracks loads and settings, predicts owners, compares
`timescale 1ns / 1ps

module cors_owner_checker
    import cors_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_beat,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_beat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_failures,
    output int                    o_pending
);

    localparam int TABLE_DEPTH = NODE_CAPACITY_DEF;
    localparam int PRINT_CAP   = 100;

    logic [POS_W-1:0]        span_start [TABLE_DEPTH];
    logic [POS_W-1:0]        span_end   [TABLE_DEPTH];
    logic [NODE_COUNT_W-1:0] searched_count = '0;
    logic [NODE_IDX_W-1:0]   fallback_node  = '0;
    t_out_item               owners_due [$];
    int                      failures = 0;

    assign o_failures = failures;

    initial begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            span_start[k] = '0;
            span_end[k]   = '0;
        end
    end

    task automatic report_mismatch(input string what);
        if (failures < PRINT_CAP) begin
            $display("[%0t] owner mismatch: %s", $time, what);
        end
        failures++;
    endtask

    // size used for tie breaks, modulo 2^32 for inverted ranges
    function automatic logic [POS_W-1:0] width_of(input int k);
        return span_end[k] - span_start[k];
    endfunction

    function automatic t_out_item owner_of_comment(input logic [POS_W-1:0] offset,
                                                   input logic [POS_W-1:0] length,
                                                   input logic trailing);
        int               limit;
        int               inner;
        int               near;
        logic [POS_W-1:0] inner_width;
        logic [POS_W-1:0] query_end;
        t_out_item        owner;
        limit       = (searched_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(searched_count);
        query_end   = offset + length;
        inner       = -1;
        near        = -1;
        inner_width = '0;
        for (int k = 0; k < limit; k++) begin
            if (span_start[k] != '0 || span_end[k] != '0) begin
                if (offset >= span_start[k] && offset < span_end[k] &&
                    (inner < 0 || width_of(k) < inner_width)) begin
                    inner       = k;
                    inner_width = width_of(k);
                end
                if (trailing) begin
                    if (span_end[k] <= offset &&
                        (near < 0 || span_end[k] > span_end[near] ||
                         (span_end[k] == span_end[near] && width_of(k) < width_of(near)))) begin
                        near = k;
                    end
                end else begin
                    if (span_start[k] >= query_end &&
                        (near < 0 || span_start[k] < span_start[near] ||
                         (span_start[k] == span_start[near] &&
                          width_of(k) < width_of(near)))) begin
                        near = k;
                    end
                end
            end
        end
        if (inner >= 0) begin
            owner.owner_idx = NODE_IDX_W'(inner);
            owner.owner_how = HOW_ENCLOSING;
        end else if (near >= 0) begin
            owner.owner_idx = NODE_IDX_W'(near);
            owner.owner_how = trailing ? HOW_PRECEDING : HOW_FOLLOWING;
        end else begin
            owner.owner_idx = fallback_node;
            owner.owner_how = HOW_ROOT;
        end
        return owner;
    endfunction

    always @(posedge i_clk) begin
        t_out_item due;
        if (!i_rst_n) begin
            searched_count = '0;
            fallback_node  = '0;
            owners_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NODE_COUNT: searched_count = i_cfg_data;
                    CFG_ROOT_NODE:  fallback_node  = i_cfg_data[NODE_IDX_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (owners_due.size() == 0) begin
                    report_mismatch($sformatf("result beat with no query waiting: node %0d how %0d",
                                              i_out_beat.owner_idx, i_out_beat.owner_how));
                end else begin
                    due = owners_due.pop_front();
                    if (i_out_beat.owner_idx !== due.owner_idx) begin
                        report_mismatch($sformatf("owner_idx %0d, expected %0d",
                                                  i_out_beat.owner_idx, due.owner_idx));
                    end
                    if (i_out_beat.owner_how !== due.owner_how) begin
                        report_mismatch($sformatf("owner_how %0d, expected %0d",
                                                  i_out_beat.owner_how, due.owner_how));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_beat.func == FUNC_LOAD) begin
                    span_start[i_in_beat.node_index] = i_in_beat.range_first;
                    span_end[i_in_beat.node_index]   = i_in_beat.range_last;
                end else begin
                    owners_due.push_back(owner_of_comment(i_in_beat.comment_offset,
                                                          i_in_beat.comment_length,
                                                          i_in_beat.comment_trailing));
                end
            end
        end
        o_pending <= owners_due.size();
    end

endmodule

>>> test/tb_comment_owner_range_search.sv
// testbench top: clock, reset, node loads and comment queries, receiver stalls and verdict
`timescale 1ns / 1ps

module tb_comment_owner_range_search;
    import cors_pkg::*;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    localparam int               RANDOM_BEATS  = 280;
    localparam int               FILL_NODES    = 256;
    localparam int               HOLD_CYCLES   = 400;
    localparam int               DRAIN_LIMIT   = 20000;
    localparam int               SETTLE_CYCLES = 1100;
    localparam longint           RUN_LIMIT_NS  = 10_000_000;
    localparam logic [POS_W-1:0] POS_MAX       = '1;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_stall;
    t_in_item              i_data     = '0;
    logic                  o_valid;
    logic                  i_stall    = 1'b0;
    t_out_item             o_data;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int         failures;
    int         owners_pending;
    t_idle_mode idle_mode     = IDLE_NONE;
    int         hold_requests = 0;
    int         holds_served  = 0;
    int         hold_left     = 0;
    int         active_nodes  = 0;

    // stimulus-side copy of loaded ranges, used only to aim query offsets
    logic [POS_W-1:0] shadow_first [NODE_CAPACITY_DEF];
    logic [POS_W-1:0] shadow_last  [NODE_CAPACITY_DEF];

    comment_owner_range_search DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    cors_owner_checker owner_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_beat   (i_data),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_beat  (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_failures  (failures),
        .o_pending   (owners_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("comment_owner_range_search verification failed");
        $finish;
    end

    function automatic bit sender_rests();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 65;
            IDLE_BOTH:   return $urandom_range(0, 99) < 6;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_rests();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 65;
            IDLE_BOTH:     return $urandom_range(0, 99) < 6;
            default:       return 1'b0;
        endcase
    endfunction

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            i_stall      <= 1'b1;
        end else begin
            i_stall <= receiver_rests();
        end
    end

    // called at a falling edge; returns at the falling edge after the beat is taken,
    // with valid still high, so the caller either sends again or lowers it
    task automatic send_beat(input t_in_item beat);
        while (sender_rests()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_node(input int idx, input logic [POS_W-1:0] from_pos,
                             input logic [POS_W-1:0] to_pos);
        t_in_item beat;
        beat.func             = FUNC_LOAD;
        beat.node_index       = NODE_IDX_W'(idx);
        beat.range_first      = from_pos;
        beat.range_last       = to_pos;
        beat.comment_offset   = $urandom;
        beat.comment_length   = $urandom;
        beat.comment_trailing = $urandom_range(0, 1);
        shadow_first[idx]     = from_pos;
        shadow_last[idx]      = to_pos;
        send_beat(beat);
    endtask

    task automatic ask_owner(input logic [POS_W-1:0] offset, input logic [POS_W-1:0] length,
                             input logic trailing);
        t_in_item beat;
        beat.func             = FUNC_QUERY;
        beat.node_index       = NODE_IDX_W'($urandom);
        beat.range_first      = $urandom;
        beat.range_last       = $urandom;
        beat.comment_offset   = offset;
        beat.comment_length   = length;
        beat.comment_trailing = trailing;
        send_beat(beat);
    endtask

    // mostly nested and overlapping ranges around base, with odd shapes mixed in
    task automatic load_random(input int idx, input logic [POS_W-1:0] base);
        logic [POS_W-1:0] from_pos;
        logic [POS_W-1:0] to_pos;
        from_pos = base + $urandom_range(0, 300);
        to_pos   = from_pos + $urandom_range(1, 120);
        case ($urandom_range(0, 19))
            0: begin
                from_pos = '0;
                to_pos   = '0;
            end
            1: {from_pos, to_pos} = {to_pos, from_pos};
            2: to_pos = '0;
            3: from_pos = POS_MAX;
            4: begin
                from_pos = $urandom;
                to_pos   = $urandom;
            end
            default: ;
        endcase
        load_node(idx, from_pos, to_pos);
    endtask

    // query aimed at a loaded range boundary most of the time
    task automatic ask_near();
        int               k;
        logic [POS_W-1:0] mark;
        logic [POS_W-1:0] offset;
        logic [POS_W-1:0] length;
        if (active_nodes == 0 || $urandom_range(0, 9) == 0) begin
            offset = ($urandom_range(0, 3) == 0) ? POS_MAX : $urandom;
        end else begin
            k    = $urandom_range(0, active_nodes - 1);
            mark = $urandom_range(0, 1) ? shadow_first[k] : shadow_last[k];
            case ($urandom_range(0, 3))
                0:       offset = mark - 1;
                1:       offset = mark;
                2:       offset = mark + 1;
                default: offset = mark + $urandom_range(0, 20) - 10;
            endcase
        end
        case ($urandom_range(0, 9))
            0, 1:    length = '0;
            2:       length = $urandom;
            default: length = $urandom_range(0, 40);
        endcase
        ask_owner(offset, length, $urandom_range(0, 1));
    endtask

    // stop sending and wait until every query has its result
    task automatic settle();
        i_valid <= 1'b0;
        while (owners_pending != 0) @(negedge i_clk);
        // a load may still be in flight after the last result
        repeat (8) @(negedge i_clk);
    endtask

    // writes both registers on back-to-back cycles; only while idle
    task automatic set_regs(input logic [NODE_COUNT_W-1:0] node_total,
                            input logic [NODE_IDX_W-1:0] root);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_NODE_COUNT;
        i_cfg_data <= CFG_DATA_W'(node_total);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_ROOT_NODE;
        i_cfg_data <= CFG_DATA_W'(root);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        active_nodes = (node_total > NODE_CAPACITY_DEF) ? NODE_CAPACITY_DEF : int'(node_total);
    endtask

    initial begin : stimulus
        int               random_beats;
        int               phase;
        int               reload;
        logic [POS_W-1:0] base;
        logic [NODE_COUNT_W-1:0] node_total;
        random_beats = 0;
        phase        = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table: every query falls back to the root
        set_regs('0, '1);
        ask_owner('0, '0, 1'b1);
        ask_owner(POS_MAX, POS_MAX, 1'b0);
        settle();

        // hand-built table: blank entry, duplicates, inverted ranges, extreme positions
        set_regs(11'd9, 10'd5);
        load_node(0, 32'd0, 32'd0);
        load_node(1, 32'd10, 32'd100);
        load_node(2, 32'd20, 32'd50);
        load_node(3, 32'd20, 32'd50);
        load_node(4, POS_MAX, 32'd5);
        load_node(5, 32'd7, 32'd0);
        load_node(6, 32'd300, 32'd400);
        load_node(7, 32'd300, 32'd350);
        load_node(8, 32'd390, 32'd400);
        ask_owner(32'd30, 32'd0, 1'b1);
        ask_owner(32'd150, 32'd0, 1'b1);
        ask_owner(32'd150, 32'd100, 1'b0);
        ask_owner(32'd450, 32'd0, 1'b1);
        ask_owner(32'd5, 32'd0, 1'b1);
        ask_owner(32'd450, POS_MAX, 1'b0);
        ask_owner(POS_MAX, 32'd1, 1'b0);
        ask_owner(32'd99, 32'd2, 1'b0);
        settle();

        // no neighbor on either side: root fallback with nodes present
        set_regs(11'd2, 10'd0);
        ask_owner(32'd5, 32'd3, 1'b1);
        ask_owner(32'd200, 32'd0, 1'b0);
        settle();

        // fill the lower part of the table, then search all of it
        idle_mode = IDLE_BOTH;
        set_regs(NODE_COUNT_W'(FILL_NODES), 10'($urandom_range(0, 1023)));
        for (int k = 0; k < FILL_NODES; k++) begin
            if (k % 32 == 0) base = $urandom;
            load_random(k, base);
        end
        repeat (6) ask_near();
        settle();

        // random phases; every searched table entry is loaded from here on
        while (random_beats < RANDOM_BEATS) begin
            settle();
            idle_mode = t_idle_mode'(phase % 4);
            case ($urandom_range(0, 9))
                0:       node_total = '0;
                1:       node_total = NODE_COUNT_W'($urandom_range(17, 160));
                default: node_total = NODE_COUNT_W'($urandom_range(1, 16));
            endcase
            set_regs(node_total, 10'($urandom_range(0, 1023)));
            base   = $urandom;
            reload = (active_nodes < 16) ? active_nodes : 16;
            for (int j = 0; j < reload; j++) begin
                load_random((active_nodes <= 16) ? j : $urandom_range(0, active_nodes - 1), base);
                random_beats++;
            end
            // one phase holds the receiver off so the block backs up into its input
            if (phase == 4) hold_requests++;
            for (int j = 0; j < 28; j++) begin
                if ($urandom_range(0, 4) == 0) begin
                    load_random((active_nodes > 0) ? $urandom_range(0, active_nodes - 1)
                                                   : $urandom_range(0, 1023), base);
                end else begin
                    ask_near();
                end
                random_beats++;
            end
            phase++;
        end

        i_valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && owners_pending != 0; n++) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (failures == 0 && owners_pending == 0) begin
            $display("comment_owner_range_search verification clean");
        end else begin
            $display("comment_owner_range_search verification failed");
        end
        $finish;
    end

endmodule
